// File: rtl/lgrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lgrs_pkg;

  localparam int ROW_WIDTH = 64;
  localparam int DATA_W    = ((ROW_WIDTH + 7) / 8) * 8;
  localparam int COLS_W    = 7;
  localparam int NBR_W     = 4;
  localparam int Q_DEPTH   = 4;
  localparam int QPTR_W    = $clog2(Q_DEPTH);
  localparam int QCNT_W    = QPTR_W + 1;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [NBR_W-1:0] BIRTH_CNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_CNT = NBR_W'(2);

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  localparam logic REG_COLS_IN_USE = 1'b0;

  typedef logic [ROW_WIDTH-1:0] row_t;

  typedef struct packed {
    logic push_a;
    logic last_a;
    logic push_b;
  } push_t;

  function automatic row_t live_mask(input logic [COLS_W-1:0] cols);
    row_t m;
    for (int c = 0; c < ROW_WIDTH; c++) begin
      m[c] = (COLS_W'(c) < cols);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/lgrs_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module lgrs_lane (
  input  wire logic [2:0] above,
  input  wire logic [2:0] here,
  input  wire logic [2:0] below,
  output logic            alive
);

  logic [lgrs_pkg::NBR_W-1:0] n;

  always_comb begin
    n = lgrs_pkg::NBR_W'(above[0]) + lgrs_pkg::NBR_W'(above[1]) + lgrs_pkg::NBR_W'(above[2])
      + lgrs_pkg::NBR_W'(here[0]) + lgrs_pkg::NBR_W'(here[2])
      + lgrs_pkg::NBR_W'(below[0]) + lgrs_pkg::NBR_W'(below[1])
      + lgrs_pkg::NBR_W'(below[2]);
    if (here[1]) begin
      alive = (n == lgrs_pkg::SURVIVE_CNT) || (n == lgrs_pkg::BIRTH_CNT);
    end else begin
      alive = (n == lgrs_pkg::BIRTH_CNT);
    end
  end

endmodule
`default_nettype wire

// File: rtl/lgrs_row_eval.sv
`timescale 1ns / 1ps
`default_nettype none
module lgrs_row_eval (
  input  wire lgrs_pkg::row_t above,
  input  wire lgrs_pkg::row_t here,
  input  wire lgrs_pkg::row_t below,
  input  wire lgrs_pkg::row_t mask,
  output lgrs_pkg::row_t      next_row
);

  logic [lgrs_pkg::ROW_WIDTH+1:0] pad_a;
  logic [lgrs_pkg::ROW_WIDTH+1:0] pad_h;
  logic [lgrs_pkg::ROW_WIDTH+1:0] pad_b;
  lgrs_pkg::row_t                 live_bits;

  assign pad_a = {1'b0, above & mask, 1'b0};
  assign pad_h = {1'b0, here & mask, 1'b0};
  assign pad_b = {1'b0, below & mask, 1'b0};

  for (genvar c = 0; c < lgrs_pkg::ROW_WIDTH; c++) begin : g_lane
    lgrs_lane u_lane (
      .above (pad_a[c+2:c]),
      .here  (pad_h[c+2:c]),
      .below (pad_b[c+2:c]),
      .alive (live_bits[c])
    );
  end

  assign next_row = live_bits & mask;

endmodule
`default_nettype wire

// File: rtl/lgrs_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module lgrs_out_queue (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lgrs_pkg::push_t                   push,
  input  wire lgrs_pkg::row_t                    row_a,
  input  wire lgrs_pkg::row_t                    row_b,
  output logic                                   room,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [lgrs_pkg::DATA_W-1:0]            out_tdata,
  output logic                                   out_tlast
);

  lgrs_pkg::row_t                 row_mem_r  [lgrs_pkg::Q_DEPTH];
  logic                           last_mem_r [lgrs_pkg::Q_DEPTH];
  logic [lgrs_pkg::QPTR_W-1:0]    wp_r, wp_nxt;
  logic [lgrs_pkg::QPTR_W-1:0]    rp_r, rp_nxt;
  logic [lgrs_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [lgrs_pkg::QPTR_W-1:0]    wp_b;
  logic                           pop;
  logic [lgrs_pkg::QCNT_W-1:0]    n_push;

  assign room       = cnt_r <= lgrs_pkg::QCNT_W'(lgrs_pkg::Q_DEPTH - 2);
  assign out_tvalid = cnt_r != '0;
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = lgrs_pkg::DATA_W'(row_mem_r[rp_r]);
  assign out_tlast  = last_mem_r[rp_r];

  always_comb begin
    n_push = lgrs_pkg::QCNT_W'(push.push_a) + lgrs_pkg::QCNT_W'(push.push_b);
    wp_b   = push.push_a ? wp_r + 1'b1 : wp_r;
    wp_nxt = wp_r + n_push[lgrs_pkg::QPTR_W-1:0];
    rp_nxt = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + n_push - lgrs_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      row_mem_r[wp_r]  <= row_a;
      last_mem_r[wp_r] <= push.last_a;
    end
    if (push.push_b) begin
      row_mem_r[wp_b]  <= row_b;
      last_mem_r[wp_b] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/life_generation_row_stencil.sv
`timescale 1ns / 1ps
`default_nettype none
// One generation of Life (B3/S23) on a grid with dead edges, one row per beat, top to bottom.
// A row is accepted every cycle while in_tready is high; all 64 column cells of the rows in
// flight are evaluated side by side by two lane arrays in the cycle the row is accepted. A
// row other than the first yields one beat for the row above it; the marked bottom row yields
// two beats (the last tagged with tlast), a one-row grid one. Results go through a four-beat
// queue, and in_tready drops only while fewer than two queue slots are free, so the queue
// drain of one beat per cycle while out_tready is high sets the rate at a bottom row.
// Register 0 (byte address 0) is cols_in_use; columns at or above it read and emit as dead.
module life_generation_row_stencil (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [lgrs_pkg::DATA_W-1:0]   in_tdata,   // [63:0] row_bits
  input  wire logic                          in_tlast,   // last_row
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [lgrs_pkg::DATA_W-1:0]        out_tdata,  // [63:0] next_row
  output logic                               out_tlast,  // last_out
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [lgrs_pkg::APB_AW-1:0]   cfg_paddr,
  input  wire logic [lgrs_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [lgrs_pkg::APB_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  logic [lgrs_pkg::COLS_W-1:0] cols_r;
  lgrs_pkg::row_t              upper_r, upper_nxt;
  lgrs_pkg::row_t              middle_r, middle_nxt;
  logic [1:0]                  seen_r, seen_nxt;
  lgrs_pkg::row_t              mask;
  lgrs_pkg::row_t              row_in;
  lgrs_pkg::row_t              a_up, a_mid, a_low;
  lgrs_pkg::row_t              res_a, res_b;
  lgrs_pkg::push_t             push;
  logic                        room;
  logic                        in_acc;
  logic                        cfg_wr;
  logic                        first;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == lgrs_pkg::REG_COLS_IN_USE);
  assign cfg_prdata = (cfg_paddr[2] == lgrs_pkg::REG_COLS_IN_USE) ?
                      lgrs_pkg::APB_DW'(cols_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= lgrs_pkg::COLS_W'(lgrs_pkg::ROW_WIDTH);
    end else if (cfg_wr) begin
      cols_r <= cfg_pwdata[lgrs_pkg::COLS_W-1:0];
    end
  end

  assign mask      = lgrs_pkg::live_mask(cols_r);
  assign row_in    = in_tdata[lgrs_pkg::ROW_WIDTH-1:0] & mask;
  assign in_tready = room;
  assign in_acc    = in_tvalid && in_tready;
  assign first     = (seen_r == lgrs_pkg::SEEN_NONE);

  always_comb begin
    if (first) begin
      a_up  = '0;
      a_mid = row_in;
      a_low = '0;
    end else begin
      a_up  = (seen_r == lgrs_pkg::SEEN_TWO) ? upper_r : '0;
      a_mid = middle_r;
      a_low = row_in;
    end
  end

  lgrs_row_eval u_eval_a (
    .above    (a_up),
    .here     (a_mid),
    .below    (a_low),
    .mask     (mask),
    .next_row (res_a)
  );

  lgrs_row_eval u_eval_b (
    .above    (middle_r),
    .here     (row_in),
    .below    ('0),
    .mask     (mask),
    .next_row (res_b)
  );

  always_comb begin
    push.push_a = in_acc && (!first || in_tlast);
    push.last_a = first;
    push.push_b = in_acc && !first && in_tlast;
    upper_nxt   = upper_r;
    middle_nxt  = middle_r;
    seen_nxt    = seen_r;
    if (in_acc) begin
      if (in_tlast) begin
        upper_nxt  = '0;
        middle_nxt = '0;
        seen_nxt   = lgrs_pkg::SEEN_NONE;
      end else if (first) begin
        upper_nxt  = '0;
        middle_nxt = row_in;
        seen_nxt   = lgrs_pkg::SEEN_ONE;
      end else begin
        upper_nxt  = middle_r;
        middle_nxt = row_in;
        seen_nxt   = lgrs_pkg::SEEN_TWO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r  <= '0;
      middle_r <= '0;
      seen_r   <= lgrs_pkg::SEEN_NONE;
    end else begin
      upper_r  <= upper_nxt;
      middle_r <= middle_nxt;
      seen_r   <= seen_nxt;
    end
  end

  lgrs_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .row_a      (res_a),
    .row_b      (res_b),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// File: rtl/lgrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lgrs_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  input  wire logic                          in_tready,
  input  wire logic                          in_tlast,
  input  wire logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic [lgrs_pkg::DATA_W-1:0]   out_tdata,
  input  wire logic                          out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("out beat changed while stalled");

  a_stall_has_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  a_empty_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("results pending right after reset");

  a_last_row_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast && !out_tvalid |=> out_tvalid)
    else $error("bottom row gave no result");

endmodule

bind life_generation_row_stencil lgrs_checker u_lgrs_checker (.*);
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lgrs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    row_t bits;
    logic last;
  } row_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tlast;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  row_beat_t   rows_to_send[$];
  row_beat_t   expected_gen[$];
  logic [COLS_W-1:0] cols_cfg = COLS_W'(64);
  row_t        grid_above = '0;
  row_t        grid_mid = '0;
  logic [1:0]  held_rows = SEEN_NONE;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          err_count = 0;
  int          cycles = 0;

  life_generation_row_stencil dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic row_t cols_mask(input logic [COLS_W-1:0] cols);
    int w;
    w = (int'(cols) > ROW_WIDTH) ? ROW_WIDTH : int'(cols);
    if (w >= 64) return '1;
    return (row_t'(1) << w) - row_t'(1);
  endfunction

  function automatic row_t next_gen(input row_t above, input row_t here, input row_t below,
                                    input row_t m);
    row_t res;
    int   n;
    int   cc;
    above &= m;
    here  &= m;
    below &= m;
    for (int c = 0; c < 64; c++) begin
      n = 0;
      for (int d = -1; d <= 1; d++) begin
        cc = c + d;
        if (cc >= 0 && cc < 64) begin
          n += int'(above[cc]) + int'(below[cc]);
          if (d != 0) n += int'(here[cc]);
        end
      end
      res[c] = here[c] ? (n == 2 || n == 3) : (n == 3);
    end
    return res & m;
  endfunction

  task automatic advance_generation(input row_t row_in, input logic last);
    row_t m;
    row_t row;
    m   = cols_mask(cols_cfg);
    row = row_in & m;
    if (held_rows == SEEN_NONE) begin
      if (last) begin
        expected_gen.insert(expected_gen.size(), row_beat_t'{next_gen('0, row, '0, m), 1'b1});
        grid_above = '0;
        grid_mid   = '0;
      end else begin
        grid_above = '0;
        grid_mid   = row;
        held_rows  = SEEN_ONE;
      end
    end else begin
      expected_gen.insert(expected_gen.size(),
                          row_beat_t'{next_gen(held_rows == SEEN_TWO ? grid_above : '0,
                                               grid_mid, row, m), 1'b0});
      if (last) begin
        expected_gen.insert(expected_gen.size(),
                            row_beat_t'{next_gen(grid_mid, row, '0, m), 1'b1});
        grid_above = '0;
        grid_mid   = '0;
        held_rows  = SEEN_NONE;
      end else begin
        grid_above = grid_mid;
        grid_mid   = row;
        held_rows  = SEEN_TWO;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input row_t got, input row_t want);
    $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_generation(in_tdata[ROW_WIDTH-1:0], in_tlast);
        void'(rows_to_send.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (rows_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= rows_to_send[0].bits;
          in_tlast  <= rows_to_send[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    row_beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_gen.size() == 0) begin
          report_mismatch("unexpected beat, next_row", out_tdata[ROW_WIDTH-1:0], '0);
        end else begin
          want = expected_gen.pop_front();
          if (out_tdata[ROW_WIDTH-1:0] !== want.bits)
            report_mismatch("next_row", out_tdata[ROW_WIDTH-1:0], want.bits);
          if (out_tlast !== want.last)
            report_mismatch("last_out", row_t'(out_tlast), row_t'(want.last));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_cols(input logic [COLS_W-1:0] cols);
    logic [APB_DW-1:0] pw;
    pw = $urandom();
    pw[COLS_W-1:0] = cols;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_AW'(REG_COLS_IN_USE) << 2;
    cfg_pwdata  <= pw;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cols_cfg = cols;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic push_row(input row_t bits, input logic last);
    rows_to_send.insert(rows_to_send.size(), row_beat_t'{bits, last});
  endtask

  function automatic row_t rand_row(input int density);
    row_t a;
    row_t b;
    a = {$urandom(), $urandom()};
    b = {$urandom(), $urandom()};
    case (density)
      1: return a & b;
      2: return a | b;
      3: return a & b & {$urandom(), $urandom()};
      default: return a;
    endcase
  endfunction

  task automatic push_frame(input int rows, input logic close);
    int density;
    density = $urandom_range(3);
    for (int r = 0; r < rows; r++)
      push_row(rand_row(density), close && (r == rows - 1));
  endtask

  task automatic drain;
    while (rows_to_send.size() != 0 || in_tvalid) @(negedge clk);
    for (int k = 0; k < 5000 && expected_gen.size() != 0; k++) @(negedge clk);
    while (expected_gen.size() != 0) begin
      report_mismatch("missing beat, next_row", '0, expected_gen[0].bits);
      void'(expected_gen.pop_front());
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      3: begin send_idle_pct = 19; recv_stall_pct = 19; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  initial begin
    logic [COLS_W-1:0] phase_cols[12];
    int sent;
    int rows;
    logic close;
    phase_cols = '{COLS_W'(64), COLS_W'(1), COLS_W'(0), COLS_W'(127), COLS_W'(2),
                   COLS_W'(3), COLS_W'(65), COLS_W'(63), COLS_W'(33),
                   COLS_W'($urandom_range(1, 64)), COLS_W'(4), COLS_W'(64)};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    write_cols(COLS_W'(64));
    set_idling(0);
    push_row('1, 1'b1);
    push_row('0, 1'b1);
    push_row(64'h8000_0000_0000_0001, 1'b1);
    push_row(64'h7, 1'b0);
    push_row('0, 1'b1);
    push_row(64'h2, 1'b0);
    push_row(64'h2, 1'b0);
    push_row(64'h2, 1'b1);
    repeat (3) push_row('1, 1'b0);
    push_row('1, 1'b1);
    push_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    push_row(64'h5555_5555_5555_5555, 1'b0);
    push_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    push_row(64'h8000_0000_0000_0001, 1'b0);
    push_row(64'hC000_0000_0000_0003, 1'b0);
    push_row(64'h8000_0000_0000_0001, 1'b1);
    push_row(64'h2, 1'b0);
    push_row(64'h4, 1'b0);
    push_row(64'h7, 1'b0);
    push_row('0, 1'b1);
    push_row('1, 1'b0);
    push_row(64'h1234_5678_9ABC_DEF0, 1'b0);
    drain();
    // narrow the grid while two rows are held
    write_cols(COLS_W'(5));
    push_row(64'hF0F0_F0F0_F0F0_F0FF, 1'b0);
    push_row(64'h0000_0000_0000_001F, 1'b1);
    drain();

    for (int p = 0; p < 12; p++) begin
      write_cols(phase_cols[p]);
      set_idling(p % 4);
      sent = 0;
      while (sent < 120) begin
        rows  = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        close = (sent + rows < 120) || (p == 11) || ($urandom_range(2) != 0);
        push_frame(rows, close);
        sent += rows;
      end
      drain();
    end

    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
